### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define HTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// checked at every edge
`define HTS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: check failed");

`endif

### design/hts_pkg.sv
package hts_pkg;

	localparam int LEVELS      = 4;
	localparam int WHEEL_SLOTS = 64;
	localparam int TIME_BITS   = 48;
	localparam int LVL_W       = $clog2(LEVELS);
	localparam int TK_W        = $clog2(LEVELS + 1);
	localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
	localparam int IDX_W       = LVL_W + SLOT_W;
	localparam int MEM_DEPTH   = LEVELS * WHEEL_SLOTS;
	localparam int TICK_W      = 21;
	localparam int SIZE_W      = 7;
	localparam int CFG_W       = 48;
	localparam int CNT_W       = $clog2(TIME_BITS);
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	localparam logic [1:0] CFG_TICK  = 2'd0;
	localparam logic [1:0] CFG_SIZE  = 2'd1;
	localparam logic [1:0] CFG_START = 2'd2;

	typedef enum logic [2:0] {
		RES_PLACED    = 3'd0,
		RES_CANCELLED = 3'd1,
		RES_EXPIRED   = 3'd2,
		RES_BEYOND    = 3'd3,
		RES_ADVANCED  = 3'd4,
		RES_UNCHANGED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		DIV_START = 2'd0,
		DIV_NOW   = 2'd1,
		DIV_EXP   = 2'd2,
		DIV_SLOT  = 2'd3
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LTK_INIT, ST_LTK_STEP, ST_LD_DIV, ST_LD_WAIT, ST_TK_INIT,
		ST_TK_STEP, ST_DISPATCH, ST_ADV_CHK, ST_ADV_WAIT, ST_ADD_CHK, ST_ADD_WAIT1,
		ST_ADD_DIV2, ST_ADD_WAIT2, ST_MEM_RD, ST_MEM_WR, ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 cmd;
		logic [TIME_BITS-1:0] expiry_time;
		logic                 is_cancelled;
		logic [TIME_BITS-1:0] now_time;
	} in_word_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [1:0]           level;
		logic [5:0]           slot;
		logic                 enqueue_bucket;
		logic [TIME_BITS-1:0] bucket_expiry;
	} out_word_t;

	typedef struct packed {
		logic     in_load;
		logic     tk_init;
		logic     tk_snap;
		logic     tk_step;
		logic     lvl_clr;
		logic     lvl_inc;
		logic     div_start;
		logic     div_take;
		div_sel_t div_sel;
		logic     pend_clr;
		logic     mem_rd;
		logic     mem_wr;
		logic     out_load;
		status_t  out_status;
	} cmd_t;

	typedef struct packed {
		logic pend;
		logic is_adv;
		logic is_cancel;
		logic adv_ge;
		logic exp_lt_lo;
		logic exp_lt_hi;
		logic lvl_last;
		logic lvl_zero;
		logic div_done;
	} sts_t;

	function automatic logic [TIME_BITS-1:0] eff_tick(input logic [TICK_W-1:0] t);
		logic [TIME_BITS-1:0] r;
		r = {{(TIME_BITS-TICK_W){1'b0}}, t};
		if (t == '0) begin
			r = {{(TIME_BITS-1){1'b0}}, 1'b1};
		end
		return r;
	endfunction

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s < SIZE_W'(2)) begin
			r = SIZE_W'(2);
		end else if (s > SIZE_W'(WHEEL_SLOTS)) begin
			r = SIZE_W'(WHEEL_SLOTS);
		end
		return r;
	endfunction

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

	function automatic logic [TIME_BITS-1:0] sat_mul(input logic [TIME_BITS-1:0] a,
			input logic [SIZE_W-1:0] b);
		logic [TIME_BITS+SIZE_W-1:0] p;
		p = {{SIZE_W{1'b0}}, a} * {{TIME_BITS{1'b0}}, b};
		return (|p[TIME_BITS+SIZE_W-1:TIME_BITS]) ? TIME_MAX : p[TIME_BITS-1:0];
	endfunction

endpackage

### design/hts_div.sv
module hts_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hts_pkg::TIME_BITS-1:0] dividend,
	input  logic [hts_pkg::TIME_BITS-1:0] divisor,
	output logic                          done,
	output logic [hts_pkg::TIME_BITS-1:0] quot,
	output logic [hts_pkg::TIME_BITS-1:0] rem
);

	logic                          busy_q;
	logic                          done_q;
	logic [hts_pkg::CNT_W-1:0]     cnt_q;
	logic [hts_pkg::TIME_BITS-1:0] rem_q;
	logic [hts_pkg::TIME_BITS-1:0] quo_q;
	logic [hts_pkg::TIME_BITS-1:0] dvs_q;
	logic [hts_pkg::TIME_BITS:0]   shift;
	logic [hts_pkg::TIME_BITS:0]   diff;

	assign shift = {rem_q, quo_q[hts_pkg::TIME_BITS-1]};
	assign diff  = shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == hts_pkg::CNT_W'(hts_pkg::TIME_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[hts_pkg::TIME_BITS]) begin
				rem_q <= diff[hts_pkg::TIME_BITS-1:0];
			end else begin
				rem_q <= shift[hts_pkg::TIME_BITS-1:0];
			end
			quo_q <= {quo_q[hts_pkg::TIME_BITS-2:0], ~diff[hts_pkg::TIME_BITS]};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

### design/hts_dp.sv
module hts_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [hts_pkg::CFG_W-1:0]  cfg_data,
	input  hts_pkg::in_word_t          in_data,
	input  hts_pkg::cmd_t              cmd,
	output hts_pkg::sts_t              sts,
	output hts_pkg::out_word_t         out_data
);

	logic [hts_pkg::TICK_W-1:0]    tick_q, snap_tick_q;
	logic [hts_pkg::SIZE_W-1:0]    size_q, snap_size_q, ws_q;
	logic [hts_pkg::TIME_BITS-1:0] start_q;
	logic                          pend_q;
	hts_pkg::in_word_t             item_q;
	logic [hts_pkg::TIME_BITS-1:0] tk_q [hts_pkg::LEVELS+1];
	logic [hts_pkg::TIME_BITS-1:0] lt_q [hts_pkg::LEVELS];
	logic [hts_pkg::LVL_W-1:0]     lvl_q;
	logic [hts_pkg::TK_W-1:0]      lvl_t, lvl_p1;
	logic [hts_pkg::TIME_BITS-1:0] now_q, v_q, qk_q, rd_q;
	logic [hts_pkg::SLOT_W-1:0]    slot_q;
	logic                          rdv_q, enq_q;
	hts_pkg::out_word_t            out_q, out_d;
	logic [hts_pkg::TIME_BITS-1:0] mem [hts_pkg::MEM_DEPTH];
	logic [hts_pkg::MEM_DEPTH-1:0] vld_q;
	logic [hts_pkg::IDX_W-1:0]     idx;
	logic [hts_pkg::TIME_BITS-1:0] dvd, dvs, quot, rem, lo_lim, hi_lim;
	logic                          div_done;

	assign lvl_t  = {{(hts_pkg::TK_W-hts_pkg::LVL_W){1'b0}}, lvl_q};
	assign lvl_p1 = lvl_t + 1'b1;
	assign idx    = {lvl_q, slot_q};
	assign lo_lim = hts_pkg::sat_add(lt_q[lvl_q], tk_q[lvl_t]);
	assign hi_lim = hts_pkg::sat_add(lt_q[lvl_q], tk_q[lvl_p1]);

	always_comb begin
		dvd = hts_pkg::TIME_MAX;
		dvs = hts_pkg::TIME_MAX;
		case (cmd.div_sel)
			hts_pkg::DIV_START: begin
				dvd = start_q;
				dvs = tk_q[lvl_t];
			end
			hts_pkg::DIV_NOW: begin
				dvd = now_q;
				dvs = tk_q[lvl_t];
			end
			hts_pkg::DIV_EXP: begin
				dvd = item_q.expiry_time;
				dvs = tk_q[lvl_t];
			end
			hts_pkg::DIV_SLOT: begin
				dvd = qk_q;
				dvs = {{(hts_pkg::TIME_BITS-hts_pkg::SIZE_W){1'b0}}, ws_q};
			end
			default: begin
				dvd = hts_pkg::TIME_MAX;
			end
		endcase
	end

	hts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= hts_pkg::TICK_W'(1);
			size_q      <= hts_pkg::SIZE_W'(20);
			start_q     <= '0;
			snap_tick_q <= hts_pkg::TICK_W'(1);
			snap_size_q <= hts_pkg::SIZE_W'(20);
			pend_q      <= 1'b0;
			lvl_q       <= '0;
			vld_q       <= '0;
			for (int i = 0; i < hts_pkg::LEVELS; i++) begin
				lt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hts_pkg::CFG_TICK: tick_q <= cfg_data[hts_pkg::TICK_W-1:0];
					hts_pkg::CFG_SIZE: size_q <= cfg_data[hts_pkg::SIZE_W-1:0];
					hts_pkg::CFG_START: begin
						start_q     <= cfg_data[hts_pkg::TIME_BITS-1:0];
						snap_tick_q <= tick_q;
						snap_size_q <= size_q;
						pend_q      <= 1'b1;
					end
					default: begin
					end
				endcase
			end else if (cmd.pend_clr) begin
				pend_q <= 1'b0;
			end
			if (cmd.lvl_clr) begin
				lvl_q <= '0;
			end else if (cmd.lvl_inc) begin
				lvl_q <= lvl_q + 1'b1;
			end
			if (cmd.div_take && (cmd.div_sel == hts_pkg::DIV_START)) begin
				lt_q[lvl_q] <= start_q - rem;
			end else if (cmd.div_take && (cmd.div_sel == hts_pkg::DIV_NOW)) begin
				lt_q[lvl_q] <= now_q - rem;
			end
			if (cmd.mem_wr) begin
				vld_q[idx] <= 1'b1;
			end
		end
	end

	always_comb begin
		out_d        = '0;
		out_d.status = cmd.out_status;
		if (cmd.out_status == hts_pkg::RES_PLACED) begin
			out_d.level          = 2'(lvl_q);
			out_d.slot           = 6'(slot_q);
			out_d.enqueue_bucket = enq_q;
			out_d.bucket_expiry  = v_q;
		end else if (cmd.out_status == hts_pkg::RES_EXPIRED) begin
			out_d.level = 2'(lvl_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			item_q <= in_data;
			now_q  <= in_data.now_time;
		end
		if (cmd.tk_init) begin
			tk_q[0] <= hts_pkg::eff_tick(cmd.tk_snap ? snap_tick_q : tick_q);
			ws_q    <= hts_pkg::eff_size(cmd.tk_snap ? snap_size_q : size_q);
		end
		if (cmd.tk_step) begin
			tk_q[lvl_p1] <= hts_pkg::sat_mul(tk_q[lvl_t], ws_q);
		end
		if (cmd.div_take) begin
			case (cmd.div_sel)
				hts_pkg::DIV_NOW: now_q <= now_q - rem;
				hts_pkg::DIV_EXP: begin
					v_q  <= item_q.expiry_time - rem;
					qk_q <= quot;
				end
				hts_pkg::DIV_SLOT: slot_q <= rem[hts_pkg::SLOT_W-1:0];
				default: begin
				end
			endcase
		end
		if (cmd.mem_rd) begin
			rd_q  <= mem[idx];
			rdv_q <= vld_q[idx];
		end
		if (cmd.mem_wr) begin
			mem[idx] <= v_q;
			enq_q    <= rdv_q ? (rd_q != v_q) : (v_q != hts_pkg::TIME_MAX);
		end
		if (cmd.out_load) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		sts.pend      = pend_q;
		sts.is_adv    = item_q.cmd;
		sts.is_cancel = item_q.is_cancelled;
		sts.adv_ge    = now_q >= lo_lim;
		sts.exp_lt_lo = item_q.expiry_time < lo_lim;
		sts.exp_lt_hi = item_q.expiry_time < hi_lim;
		sts.lvl_last  = lvl_q == hts_pkg::LVL_W'(hts_pkg::LEVELS - 1);
		sts.lvl_zero  = lvl_q == '0;
		sts.div_done  = div_done;
	end

	assign out_data = out_q;

endmodule

### design/hts_ctrl.sv
`include "assert_macros.svh"

module hts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  hts_pkg::sts_t sts,
	output hts_pkg::cmd_t cmd
);

	hts_pkg::state_t  state_q, state_d;
	hts_pkg::status_t res_q, res_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hts_pkg::ST_IDLE;
			res_q       <= hts_pkg::RES_PLACED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd            = '0;
		cmd.div_sel    = hts_pkg::DIV_START;
		cmd.out_status = res_q;
		case (state_q)
			hts_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = sts.pend ? hts_pkg::ST_LTK_INIT : hts_pkg::ST_TK_INIT;
				end
			end
			hts_pkg::ST_LTK_INIT: begin
				cmd.tk_init = 1'b1;
				cmd.tk_snap = 1'b1;
				cmd.lvl_clr = 1'b1;
				state_d     = hts_pkg::ST_LTK_STEP;
			end
			hts_pkg::ST_LTK_STEP: begin
				cmd.tk_step = 1'b1;
				if (sts.lvl_last) begin
					cmd.lvl_clr = 1'b1;
					state_d     = hts_pkg::ST_LD_DIV;
				end else begin
					cmd.lvl_inc = 1'b1;
				end
			end
			hts_pkg::ST_LD_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = hts_pkg::ST_LD_WAIT;
			end
			hts_pkg::ST_LD_WAIT: begin
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					if (sts.lvl_last) begin
						cmd.pend_clr = 1'b1;
						state_d      = hts_pkg::ST_TK_INIT;
					end else begin
						cmd.lvl_inc = 1'b1;
						state_d     = hts_pkg::ST_LD_DIV;
					end
				end
			end
			hts_pkg::ST_TK_INIT: begin
				cmd.tk_init = 1'b1;
				cmd.lvl_clr = 1'b1;
				state_d     = hts_pkg::ST_TK_STEP;
			end
			hts_pkg::ST_TK_STEP: begin
				cmd.tk_step = 1'b1;
				if (sts.lvl_last) begin
					cmd.lvl_clr = 1'b1;
					state_d     = hts_pkg::ST_DISPATCH;
				end else begin
					cmd.lvl_inc = 1'b1;
				end
			end
			hts_pkg::ST_DISPATCH: begin
				if (sts.is_adv) begin
					res_d   = hts_pkg::RES_UNCHANGED;
					state_d = hts_pkg::ST_ADV_CHK;
				end else if (sts.is_cancel) begin
					res_d   = hts_pkg::RES_CANCELLED;
					state_d = hts_pkg::ST_FINISH;
				end else begin
					res_d   = hts_pkg::RES_BEYOND;
					state_d = hts_pkg::ST_ADD_CHK;
				end
			end
			hts_pkg::ST_ADV_CHK: begin
				cmd.div_sel = hts_pkg::DIV_NOW;
				if (sts.adv_ge) begin
					cmd.div_start = 1'b1;
					state_d       = hts_pkg::ST_ADV_WAIT;
				end else begin
					state_d = hts_pkg::ST_FINISH;
				end
			end
			hts_pkg::ST_ADV_WAIT: begin
				cmd.div_sel = hts_pkg::DIV_NOW;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					if (sts.lvl_zero) begin
						res_d = hts_pkg::RES_ADVANCED;
					end
					if (sts.lvl_last) begin
						state_d = hts_pkg::ST_FINISH;
					end else begin
						cmd.lvl_inc = 1'b1;
						state_d     = hts_pkg::ST_ADV_CHK;
					end
				end
			end
			hts_pkg::ST_ADD_CHK: begin
				cmd.div_sel = hts_pkg::DIV_EXP;
				if (sts.exp_lt_lo) begin
					res_d   = hts_pkg::RES_EXPIRED;
					state_d = hts_pkg::ST_FINISH;
				end else if (sts.exp_lt_hi) begin
					cmd.div_start = 1'b1;
					state_d       = hts_pkg::ST_ADD_WAIT1;
				end else if (sts.lvl_last) begin
					state_d = hts_pkg::ST_FINISH;
				end else begin
					cmd.lvl_inc = 1'b1;
				end
			end
			hts_pkg::ST_ADD_WAIT1: begin
				cmd.div_sel = hts_pkg::DIV_EXP;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = hts_pkg::ST_ADD_DIV2;
				end
			end
			hts_pkg::ST_ADD_DIV2: begin
				cmd.div_sel   = hts_pkg::DIV_SLOT;
				cmd.div_start = 1'b1;
				state_d       = hts_pkg::ST_ADD_WAIT2;
			end
			hts_pkg::ST_ADD_WAIT2: begin
				cmd.div_sel = hts_pkg::DIV_SLOT;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = hts_pkg::ST_MEM_RD;
				end
			end
			hts_pkg::ST_MEM_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = hts_pkg::ST_MEM_WR;
			end
			hts_pkg::ST_MEM_WR: begin
				cmd.mem_wr = 1'b1;
				res_d      = hts_pkg::RES_PLACED;
				state_d    = hts_pkg::ST_FINISH;
			end
			hts_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = hts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hts_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall  = state_q != hts_pkg::ST_IDLE;
	assign out_valid = out_valid_q;

	`HTS_ASSERT(a_accept_starts, clk, arst_n, (in_valid && !in_stall) |=> (state_q == hts_pkg::ST_LTK_INIT || state_q == hts_pkg::ST_TK_INIT))
	`HTS_ASSERT(a_result_from_finish, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == hts_pkg::ST_FINISH))
	`HTS_ASSERT(a_div_awaited, clk, arst_n, sts.div_done |-> (state_q == hts_pkg::ST_LD_WAIT || state_q == hts_pkg::ST_ADV_WAIT || state_q == hts_pkg::ST_ADD_WAIT1 || state_q == hts_pkg::ST_ADD_WAIT2))

endmodule

### design/hierarchical_timer_slot_placer.sv
// Timing wheel placement engine, one word at a time. Each accepted word first rebuilds
// the level ticks, then dispatches it. Add then checks levels one per cycle and, when
// placed, runs two divisions on the shared 48-step bit-serial divider plus a bucket
// read and write. Advance runs one division per level that moves and stops at the
// first level that does not. The first word after a start_ms write also reloads the
// four level times. A result held by out_stall holds back the result of the next
// word. One result per word.
module hierarchical_timer_slot_placer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [hts_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  hts_pkg::in_word_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output hts_pkg::out_word_t        out_data
);

	hts_pkg::cmd_t cmd;
	hts_pkg::sts_t sts;

	hts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	hts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
